// ----- rtl/scc_pkg.sv -----
// Shared types, codes and symbol tables for the straddling checkerboard codec.
// No dependencies; imported by scc_outq, straddling_checkerboard_codec, scc_checker and tb.
package scc_pkg;

    // Operation codes carried in the low bits of the input request
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_KEY    = 3'd1;
    localparam logic [2:0] OP_BUILD  = 3'd2;
    localparam logic [2:0] OP_ENCODE = 3'd3;
    localparam logic [2:0] OP_DECODE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_BLANK  = 2'd0;
    localparam logic [1:0] CFG_SECOND_BLANK = 2'd1;

    localparam int unsigned NUM_SYMBOLS = 28;
    localparam int unsigned NUM_CELLS   = 30;
    localparam int unsigned DEFAULT_LEN = 27;
    localparam logic [7:0]  CHAR_SPACE  = 8'h20;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_BINIT,
        ST_BRD,
        ST_BWR
    } state_t;

    // Up to two result pushes per request into the output queue
    typedef struct packed {
        logic       v0;
        logic [8:0] d0;   // {last, char}
        logic       v1;
        logic [8:0] d1;   // {last, char}
    } push_t;

    // Default fill order ESTONIARBCDFGHKLMPQUVWXYZ.# as symbol numbers
    localparam logic [4:0] DEFAULT_ORDER [DEFAULT_LEN] = '{
        5'd4,  5'd18, 5'd19, 5'd14, 5'd13, 5'd8,  5'd0,  5'd17, 5'd1,
        5'd2,  5'd3,  5'd5,  5'd6,  5'd7,  5'd10, 5'd11, 5'd12, 5'd15,
        5'd16, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27
    };

    // ASCII to {valid, symbol}; lower case folds to upper case
    function automatic logic [5:0] sym_index(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] off;
        logic [5:0] res;
        u   = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
        off = u - 8'h41;
        res = 6'd0;
        if (u >= 8'h41 && u <= 8'h5A) res = {1'b1, off[4:0]};
        else if (u == 8'h2E)          res = {1'b1, 5'd26};
        else if (u == 8'h23)          res = {1'b1, 5'd27};
        return res;
    endfunction

    // Symbol number to ASCII
    function automatic logic [7:0] char_of_sym(input logic [4:0] s);
        logic [7:0] res;
        if (s < 5'd26)       res = 8'h41 + {3'b000, s};
        else if (s == 5'd26) res = 8'h2E;
        else                 res = 8'h23;
        return res;
    endfunction

    // Effective blank columns: saturate at nine, equal values split apart
    function automatic logic [7:0] eff_blanks(input logic [3:0] fb, input logic [3:0] sb);
        logic [3:0] a;
        logic [3:0] b;
        a = (fb > 4'd9) ? 4'd9 : fb;
        b = (sb > 4'd9) ? 4'd9 : sb;
        if (a == b) b = (a == 4'd9) ? 4'd0 : a + 4'd1;
        return {b, a};
    endfunction

endpackage

// ----- rtl/scc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/scc_outq.sv -----
// Four-entry result queue between the codec core and the output stream.
// Depends on scc_pkg (push_t).
module scc_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  scc_pkg::push_t push,
    input  logic           pop,
    output logic           valid,
    output logic [8:0]     head,
    output logic           room
);

    import scc_pkg::*;

    logic [8:0] entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 2'd1;
    assign valid        = (cnt_reg != 3'd0);
    assign head         = entry_reg[rd_ptr_reg];
    // room for the two results one request may cause
    assign room         = (cnt_reg <= 3'd2);

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {1'b0, push.v0} + {1'b0, push.v1};
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        cnt_next    = cnt_reg + {2'b00, push.v0} + {2'b00, push.v1} - {2'b00, pop};
    end

    // queue storage, payload only
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            entry_reg[wr_ptr_reg] <= push.d0;
        end
        if (push.v1)
        begin
            entry_reg[wr_ptr_plus1] <= push.d1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/straddling_checkerboard_codec.sv -----
// Straddling checkerboard codec over A-Z, '.' and '#'; board, positions and keyword in RAMs.
// Encode/decode: a request goes to a lookup state that pushes its result into the output
// queue; no new request is taken until then. A build walks the 30 board cells in a read and
// a write state each, plus a write-state pass per skipped keyword symbol, with s_axis_tready
// low. Reset (async, rst_n low) clears control state and then runs the same build for the
// default layout before the first request; a write to either blank register also rebuilds.
module straddling_checkerboard_codec (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] operation, [10:3] text_char, [15:11] zero
    input  logic        s_axis_tlast,   // end_of_text
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast    // last_of_run
);

    import scc_pkg::*;

    state_t      state_reg, state_next;
    logic [3:0]  fb_reg, sb_reg;
    logic [3:0]  blank1, blank2;
    logic [4:0]  kc_reg, kc_next;
    logic [27:0] used_reg, used_next;
    logic [27:0] pos_valid_reg, pos_valid_next;
    logic [1:0]  pend_reg, pend_next;
    logic        build_req_reg, build_req_next;
    logic        look_enc_reg, look_enc_next;
    logic        look_hit_reg, look_hit_next;
    logic [4:0]  cell_reg, cell_next;
    logic [1:0]  row_reg, row_next;
    logic [3:0]  col_reg, col_next;
    logic [4:0]  idx_reg, idx_next;
    logic [4:0]  sym_reg, sym_next;

    logic        acc;
    logic [2:0]  in_op;
    logic [7:0]  in_char;
    logic        in_eot;
    logic [5:0]  in_sym_full;
    logic        in_sym_ok;
    logic [4:0]  in_sym;
    logic        cfg_hit;
    logic        key_we;
    logic        q_room;
    logic        q_valid;
    logic [8:0]  q_head;
    push_t       push;

    logic        digit;
    logic [3:0]  dig;
    logic        dec_emit;
    logic [4:0]  dec_addr;

    logic [4:0]  key_rd;
    logic [5:0]  pos_rd;
    logic [7:0]  cell_rd;

    logic        cell_we;
    logic [7:0]  cell_wdata;
    logic        pos_we;
    logic [4:0]  b_sym;
    logic        adv_cell, adv_idx, adv_sym;
    logic [31:0] used_ext;
    logic [4:0]  seq_len;
    logic        top_blank;
    logic [7:0]  blanks;

    // request fields and handshake
    assign in_op       = s_axis_tdata[2:0];
    assign in_char     = s_axis_tdata[10:3];
    assign in_eot      = s_axis_tlast;
    assign in_sym_full = sym_index(in_char);
    assign in_sym_ok   = in_sym_full[5];
    assign in_sym      = in_sym_full[4:0];
    assign s_axis_tready = (state_reg == ST_IDLE) && !build_req_reg && q_room;
    assign acc         = s_axis_tvalid && s_axis_tready;

    assign blanks  = eff_blanks(fb_reg, sb_reg);
    assign blank1  = blanks[3:0];
    assign blank2  = blanks[7:4];
    assign cfg_hit = cfg_we && (cfg_index == CFG_FIRST_BLANK || cfg_index == CFG_SECOND_BLANK);

    // new keyword letter: A-Z only, not yet seen, room left
    assign key_we = acc && (in_op == OP_KEY) && in_sym_ok && (in_sym < 5'd26)
                    && !used_reg[in_sym] && (kc_reg < 5'(NUM_SYMBOLS));

    // decode: digit parsing against the pending prefix
    always_comb
    begin
        digit    = (in_char >= 8'h30) && (in_char <= 8'h39);
        dig      = digit ? in_char[3:0] : 4'd0;
        dec_emit = 1'b0;
        dec_addr = {1'b0, dig};
        if (pend_reg == 2'd1 || pend_reg == 2'd2)
        begin
            dec_emit = digit;
            dec_addr = (pend_reg == 2'd1) ? 5'd10 + {1'b0, dig} : 5'd20 + {1'b0, dig};
        end
        else if (digit && dig != blank1 && dig != blank2)
        begin
            dec_emit = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (build_req_reg)
                    state_next = ST_BINIT;
                else if (acc && (in_op == OP_ENCODE || in_op == OP_DECODE))
                    state_next = ST_LOOK;
            end
            ST_LOOK:  state_next = ST_IDLE;
            ST_BINIT: state_next = ST_BRD;
            ST_BRD:   state_next = ST_BWR;
            ST_BWR:
            begin
                if (adv_cell)
                    state_next = (cell_reg == 5'(NUM_CELLS - 1)) ? ST_IDLE : ST_BRD;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: board walk writes and result pushes
    always_comb
    begin
        used_ext   = {4'b0000, used_reg};
        seq_len    = (kc_reg == 5'd0) ? 5'(DEFAULT_LEN) : 5'(NUM_SYMBOLS);
        top_blank  = (row_reg == 2'd0) && (col_reg == blank1 || col_reg == blank2);
        cell_we    = 1'b0;
        cell_wdata = CHAR_SPACE;
        pos_we     = 1'b0;
        b_sym      = sym_reg;
        adv_cell   = 1'b0;
        adv_idx    = 1'b0;
        adv_sym    = 1'b0;
        push       = '0;

        unique case (state_reg)
            ST_BWR:
            begin
                if (top_blank || idx_reg >= seq_len)
                begin
                    cell_we  = 1'b1;
                    adv_cell = 1'b1;
                end
                else if (kc_reg == 5'd0)
                begin
                    b_sym    = DEFAULT_ORDER[idx_reg];
                    cell_we  = 1'b1;
                    pos_we   = 1'b1;
                    adv_cell = 1'b1;
                    adv_idx  = 1'b1;
                end
                else if (idx_reg < kc_reg)
                begin
                    b_sym    = key_rd;
                    cell_we  = 1'b1;
                    pos_we   = 1'b1;
                    adv_cell = 1'b1;
                    adv_idx  = 1'b1;
                end
                else if (used_ext[sym_reg])
                begin
                    // keyword letter already placed: skip it
                    adv_sym = 1'b1;
                end
                else
                begin
                    cell_we  = 1'b1;
                    pos_we   = 1'b1;
                    adv_cell = 1'b1;
                    adv_idx  = 1'b1;
                    adv_sym  = 1'b1;
                end
                if (pos_we)
                    cell_wdata = char_of_sym(b_sym);
            end
            ST_LOOK:
            begin
                if (look_hit_reg && look_enc_reg)
                begin
                    if (pos_rd[5:4] == 2'd1 || pos_rd[5:4] == 2'd2)
                    begin
                        push.v0 = 1'b1;
                        push.d0 = {1'b0, CHAR_ZERO
                                   + {4'd0, (pos_rd[5:4] == 2'd1) ? blank1 : blank2}};
                        push.v1 = 1'b1;
                        push.d1 = {1'b1, CHAR_ZERO + {4'd0, pos_rd[3:0]}};
                    end
                    else
                    begin
                        push.v0 = 1'b1;
                        push.d0 = {1'b1, CHAR_ZERO + {4'd0, pos_rd[3:0]}};
                    end
                end
                else if (look_hit_reg)
                begin
                    push.v0 = 1'b1;
                    push.d0 = {1'b1, cell_rd};
                end
            end
            default:
            begin
            end
        endcase
    end

    // next values of the control state
    always_comb
    begin
        kc_next        = kc_reg;
        used_next      = used_reg;
        pos_valid_next = pos_valid_reg;
        pend_next      = pend_reg;
        look_enc_next  = look_enc_reg;
        look_hit_next  = look_hit_reg;
        cell_next      = cell_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        idx_next       = idx_reg;
        sym_next       = sym_reg;
        build_req_next = cfg_hit || (acc && in_op == OP_BUILD)
                         || (build_req_reg && state_reg != ST_IDLE);

        // keyword bookkeeping
        if (acc && in_op == OP_CLEAR)
        begin
            kc_next   = 5'd0;
            used_next = '0;
        end
        if (key_we)
        begin
            kc_next   = kc_reg + 5'd1;
            used_next = used_reg | (28'd1 << in_sym);
        end

        // lookup request captured for the next cycle
        if (acc)
        begin
            look_enc_next = (in_op == OP_ENCODE);
            look_hit_next = (in_op == OP_ENCODE) ? (in_sym_ok && pos_valid_reg[in_sym])
                                                 : dec_emit;
            if (in_op == OP_DECODE)
            begin
                if (pend_reg == 2'd1 || pend_reg == 2'd2)
                    pend_next = 2'd0;
                else if (digit)
                    pend_next = (dig == blank1) ? 2'd1 : (dig == blank2) ? 2'd2 : 2'd0;
            end
            if (in_eot)
                pend_next = 2'd0;
        end

        // board walk counters
        if (state_reg == ST_BINIT)
        begin
            pos_valid_next = '0;
            cell_next      = 5'd0;
            row_next       = 2'd0;
            col_next       = 4'd0;
            idx_next       = 5'd0;
            sym_next       = 5'd0;
        end
        if (pos_we)
            pos_valid_next = pos_valid_reg | (28'd1 << b_sym);
        if (adv_cell)
        begin
            cell_next = cell_reg + 5'd1;
            if (col_reg == 4'd9)
            begin
                col_next = 4'd0;
                row_next = row_reg + 2'd1;
            end
            else
            begin
                col_next = col_reg + 4'd1;
            end
        end
        if (adv_idx)
            idx_next = idx_reg + 5'd1;
        if (adv_sym)
            sym_next = sym_reg + 5'd1;
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fb_reg        <= 4'd2;
            sb_reg        <= 4'd6;
            kc_reg        <= 5'd0;
            used_reg      <= '0;
            pos_valid_reg <= '0;
            pend_reg      <= 2'd0;
            build_req_reg <= 1'b1;
            look_enc_reg  <= 1'b0;
            look_hit_reg  <= 1'b0;
            cell_reg      <= 5'd0;
            row_reg       <= 2'd0;
            col_reg       <= 4'd0;
            idx_reg       <= 5'd0;
            sym_reg       <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we && cfg_index == CFG_FIRST_BLANK)
                fb_reg <= cfg_wdata;
            if (cfg_we && cfg_index == CFG_SECOND_BLANK)
                sb_reg <= cfg_wdata;
            kc_reg        <= kc_next;
            used_reg      <= used_next;
            pos_valid_reg <= pos_valid_next;
            pend_reg      <= pend_next;
            build_req_reg <= build_req_next;
            look_enc_reg  <= look_enc_next;
            look_hit_reg  <= look_hit_next;
            cell_reg      <= cell_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            idx_reg       <= idx_next;
            sym_reg       <= sym_next;
        end
    end

    // keyword letters in order of arrival
    scc_ram #(.WIDTH(5), .DEPTH(28)) u_key_ram (
        .clk     (clk),
        .we      (key_we),
        .wr_addr (kc_reg),
        .wr_data (in_sym),
        .rd_addr (idx_reg),
        .rd_data (key_rd)
    );

    // symbol positions {row, column}; validity kept in pos_valid_reg
    scc_ram #(.WIDTH(6), .DEPTH(28)) u_pos_ram (
        .clk     (clk),
        .we      (pos_we),
        .wr_addr (b_sym),
        .wr_data ({row_reg, col_reg}),
        .rd_addr (in_sym),
        .rd_data (pos_rd)
    );

    // board cells as ASCII
    scc_ram #(.WIDTH(8), .DEPTH(30)) u_cell_ram (
        .clk     (clk),
        .we      (cell_we),
        .wr_addr (cell_reg),
        .wr_data (cell_wdata),
        .rd_addr (dec_addr),
        .rd_data (cell_rd)
    );

    // result queue
    scc_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (m_axis_tvalid && m_axis_tready),
        .valid (q_valid),
        .head  (q_head),
        .room  (q_room)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = q_head[7:0];
    assign m_axis_tlast  = q_head[8];

    // keyword count and mask stay in step
    a_key_sync: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == 32'(kc_reg))
        else $error("keyword count and used mask disagree");

    // an accepted lookup is served in the following cycle
    a_look_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (in_op == OP_ENCODE || in_op == OP_DECODE)) |=> (state_reg == ST_LOOK))
        else $error("lookup request not followed by lookup cycle");

    // the walk never runs past the last cell
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BWR) |-> (cell_reg <= 5'(NUM_CELLS - 1)))
        else $error("board walk beyond last cell");

    // the unused-symbol scan stays in range while symbols remain to place
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BWR && kc_reg != 5'd0 && idx_reg >= kc_reg
         && idx_reg < 5'(NUM_SYMBOLS)) |-> (sym_reg < 5'(NUM_SYMBOLS)))
        else $error("symbol scan out of range");

endmodule

// ----- tb/scc_checker.sv -----
// Scoreboard for the straddling checkerboard codec: tracks register writes and requests,
// predicts result characters and compares them with the result stream.
// Depends on scc_pkg (operation codes, register indexes, character constants).
`timescale 1ns / 1ps

module scc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] operation, [10:3] text_char, [15:11] zero
    input  logic        s_axis_tlast,   // end_of_text
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] out_char
    input  logic        m_axis_tlast,   // last_of_run
    output int          fail_count,
    output int          n_waiting
);
    import scc_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int DEFAULT_COUNT = 27;
    localparam logic [8*27-1:0] DEFAULT_FILL = "ESTONIARBCDFGHKLMPQUVWXYZ.#";

    // Decode prefix codes
    localparam logic [1:0] PREFIX_NONE = 2'd0;
    localparam logic [1:0] PREFIX_ROW1 = 2'd1;
    localparam logic [1:0] PREFIX_ROW2 = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } result_t;

    // Shadow of the codec state
    logic [3:0] first_blank_q;
    logic [3:0] second_blank_q;
    logic [4:0] key_order [NUM_SYMBOLS];
    logic [4:0] key_count;
    logic [27:0] used_mask;
    logic [7:0] board [NUM_CELLS];
    logic [6:0] position [NUM_SYMBOLS];
    logic [1:0] prefix;

    result_t expected_chars [$];

    // ASCII to symbol number, -1 when not one of the 28 symbols
    function automatic int symbol_of(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= "a" && c <= "z") u = c - 8'd32;
        if (u >= "A" && u <= "Z") return int'(u - "A");
        if (u == ".") return 26;
        if (u == "#") return 27;
        return -1;
    endfunction

    function automatic logic [7:0] char_of(input int s);
        if (s < 26) return 8'("A" + s);
        return (s == 26) ? "." : "#";
    endfunction

    // Effective blank columns
    function automatic int blank_one();
        return (first_blank_q > 4'd9) ? 9 : int'(first_blank_q);
    endfunction

    function automatic int blank_two();
        int a;
        int b;
        a = blank_one();
        b = (second_blank_q > 4'd9) ? 9 : int'(second_blank_q);
        if (b == a) b = (a + 1) % 10;
        return b;
    endfunction

    // Lay out the board and refill the position table
    task automatic rebuild_board();
        logic [7:0] fill [NUM_SYMBOLS];
        logic [1:0] row;
        logic [3:0] col;
        int n;
        int idx;
        int b1;
        int b2;
        int k;
        n = 0;
        idx = 0;
        b1 = blank_one();
        b2 = blank_two();
        if (key_count == 5'd0) begin
            for (int i = 0; i < DEFAULT_COUNT; i++) begin
                fill[n] = DEFAULT_FILL[8*(DEFAULT_COUNT-1-i) +: 8];
                n++;
            end
        end
        else begin
            for (int i = 0; i < key_count; i++) begin
                fill[n] = char_of(key_order[i]);
                n++;
            end
            for (int s = 0; s < NUM_SYMBOLS && n < NUM_SYMBOLS; s++) begin
                if (!used_mask[s]) begin
                    fill[n] = char_of(s);
                    n++;
                end
            end
        end
        for (int i = 0; i < NUM_CELLS; i++) board[i] = CHAR_SPACE;
        for (int c = 0; c < 10; c++) begin
            if (c != b1 && c != b2 && idx < n) begin
                board[c] = fill[idx];
                idx++;
            end
        end
        for (int c = 10; c < NUM_CELLS && idx < n; c++) begin
            board[c] = fill[idx];
            idx++;
        end
        for (int s = 0; s < NUM_SYMBOLS; s++) position[s] = '0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            k = symbol_of(board[i]);
            if (board[i] != CHAR_SPACE && k >= 0) begin
                row = 2'(i / 10);
                col = 4'(i % 10);
                position[k] = {1'b1, row, col};
            end
        end
    endtask

    task automatic reset_shadow();
        first_blank_q = 4'd2;
        second_blank_q = 4'd6;
        for (int i = 0; i < NUM_SYMBOLS; i++) key_order[i] = '0;
        key_count = '0;
        used_mask = '0;
        prefix = PREFIX_NONE;
        rebuild_board();
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last);
        result_t r;
        r.ch = ch;
        r.last = last;
        expected_chars.push_back(r);
        n_waiting = expected_chars.size();
    endtask

    // Work out the result characters of one request and update the shadow
    task automatic predict_request(input logic [2:0] op, input logic [7:0] ch,
                                   input logic eot);
        int s;
        int d;
        int b1;
        int b2;
        logic digit;
        logic [6:0] p;
        b1 = blank_one();
        b2 = blank_two();
        s = symbol_of(ch);
        digit = (ch >= "0" && ch <= "9");
        d = digit ? int'(ch) - int'(CHAR_ZERO) : 0;
        case (op)
            OP_CLEAR: begin
                key_count = '0;
                used_mask = '0;
            end
            OP_KEY: begin
                // letters only, each kept once
                if (s >= 0 && s < 26 && !used_mask[s] && key_count < NUM_SYMBOLS) begin
                    key_order[key_count] = 5'(s);
                    key_count = key_count + 5'd1;
                    used_mask[s] = 1'b1;
                end
            end
            OP_BUILD: rebuild_board();
            OP_ENCODE: begin
                if (s >= 0) begin
                    p = position[s];
                    if (p[6]) begin
                        if (p[5:4] == 2'd1) push_char(CHAR_ZERO + 8'(b1), 1'b0);
                        else if (p[5:4] == 2'd2) push_char(CHAR_ZERO + 8'(b2), 1'b0);
                        push_char(CHAR_ZERO + p[3:0], 1'b1);
                    end
                end
            end
            OP_DECODE: begin
                if (prefix == PREFIX_ROW1 || prefix == PREFIX_ROW2) begin
                    // any character after a prefix consumes it
                    if (digit) push_char(board[int'(prefix) * 10 + d], 1'b1);
                    prefix = PREFIX_NONE;
                end
                else if (digit) begin
                    prefix = PREFIX_NONE;
                    if (d == b1) begin
                        if (!eot) prefix = PREFIX_ROW1;
                    end
                    else if (d == b2) begin
                        if (!eot) prefix = PREFIX_ROW2;
                    end
                    else begin
                        push_char(board[d], 1'b1);
                    end
                end
            end
            default: ;
        endcase
        if (eot) prefix = PREFIX_NONE;
    endtask

    // Compare one result against the oldest expectation
    task automatic check_result();
        result_t want;
        if (expected_chars.size() == 0) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: unexpected result char %h last %b",
                         $realtime, m_axis_tdata, m_axis_tlast);
            fail_count++;
        end
        else begin
            want = expected_chars.pop_front();
            n_waiting = expected_chars.size();
            if (want.ch !== m_axis_tdata || want.last !== m_axis_tlast) begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: mismatch: expected char %h last %b, got char %h last %b",
                             $realtime, want.ch, want.last, m_axis_tdata, m_axis_tlast);
                fail_count++;
            end
        end
    endtask

    // Register writes, requests and results, processed in that order
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            reset_shadow();
            expected_chars.delete();
            n_waiting = 0;
            fail_count = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FIRST_BLANK: begin
                        first_blank_q = cfg_wdata;
                        rebuild_board();
                    end
                    CFG_SECOND_BLANK: begin
                        second_blank_q = cfg_wdata;
                        rebuild_board();
                    end
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tdata[2:0], s_axis_tdata[10:3], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the straddling checkerboard codec: clock, reset, register writes,
// directed and random request traffic with idling phases, watchdog and verdict.
// Depends on scc_pkg, straddling_checkerboard_codec and scc_checker.
`timescale 1ns / 1ps

module tb;
    import scc_pkg::*;

    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 450;
    localparam int NUM_PHASES     = 8;

    // Codes the block ignores
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [7:0]  m_axis_tdata;
    wire         m_axis_tlast;

    int fail_count;
    int n_waiting;
    int idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;
    int items_sent = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    straddling_checkerboard_codec u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    scc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .n_waiting     (n_waiting)
    );

    // Result side back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog on cycles with no request and no result moving
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // One request, after a random gap; returns at the edge that accepts it
    task automatic send(input logic [2:0] op, input logic [7:0] ch, input logic eot);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b00000, ch, op};
        s_axis_tlast  <= eot;
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
        if (op < OP_SPARE_LO) items_sent++;
    endtask

    // Wait for every expected result, then for any build still running
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (n_waiting != 0) @(negedge clk);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; a write to either blank register triggers a rebuild, so let it finish
    task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_plain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'("A" + $urandom_range(0, 25));
        if (r < 75) return 8'("a" + $urandom_range(0, 25));
        if (r < 85) return $urandom_range(0, 1) ? "." : "#";
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_cipher();
        if ($urandom_range(0, 99) < 88) return 8'(CHAR_ZERO + $urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'("A" + $urandom_range(0, 25));
        if (r < 75) return 8'("a" + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // One message: keyword set-up, plaintext, ciphertext or noise
    task automatic random_sequence();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            send(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0);
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++) send(OP_KEY, pick_key(), 1'b0);
            send(OP_BUILD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        else if (kind < 50) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) send(OP_ENCODE, pick_plain(), i == len - 1);
        end
        else if (kind < 88) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) send(OP_DECODE, pick_cipher(), i == len - 1);
        end
        else begin
            send(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default layout: top row, both prefix rows, missing J, odd bytes
        send(OP_ENCODE, "E", 1'b0);
        send(OP_ENCODE, "b", 1'b0);
        send(OP_ENCODE, "#", 1'b0);
        send(OP_ENCODE, "J", 1'b0);
        send(OP_ENCODE, 8'h00, 1'b0);
        send(OP_ENCODE, 8'hFF, 1'b1);
        // Decode: prefixed pairs, empty cell, consumed prefix, dropped prefix
        send(OP_DECODE, "2", 1'b0);
        send(OP_DECODE, "0", 1'b0);
        send(OP_DECODE, "6", 1'b0);
        send(OP_DECODE, "9", 1'b0);
        send(OP_DECODE, "9", 1'b0);
        send(OP_DECODE, "2", 1'b0);
        send(OP_DECODE, "x", 1'b0);
        send(OP_DECODE, "q", 1'b0);
        send(OP_DECODE, "6", 1'b1);
        send(OP_DECODE, "0", 1'b1);
        send(OP_SPARE_LO, "2", 1'b1);
        send(OP_SPARE_HI, 8'hAA, 1'b0);
        // Keyword with no letters falls back to the default order
        send(OP_CLEAR, 8'h00, 1'b0);
        send(OP_KEY, ".", 1'b0);
        send(OP_KEY, "3", 1'b0);
        send(OP_BUILD, 8'h00, 1'b0);
        // Keyword with a repeat and mixed case
        send(OP_CLEAR, 8'h00, 1'b0);
        send(OP_KEY, "k", 1'b0);
        send(OP_KEY, "E", 1'b0);
        send(OP_KEY, "y", 1'b0);
        send(OP_KEY, "e", 1'b0);
        send(OP_BUILD, 8'h00, 1'b0);
        send(OP_ENCODE, "J", 1'b0);
        send(OP_ENCODE, "#", 1'b1);
        send(OP_DECODE, "6", 1'b0);
        send(OP_DECODE, "8", 1'b1);

        // Random phases, each with its own blanks and idling mix
        items_sent = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            case (phase)
                0: ;
                1: begin
                    write_reg(CFG_FIRST_BLANK, 4'd0);
                    write_reg(CFG_SECOND_BLANK, 4'd9);
                end
                2: begin
                    // equal blanks at the top end wrap to zero
                    write_reg(CFG_FIRST_BLANK, 4'd9);
                    write_reg(CFG_SECOND_BLANK, 4'd9);
                end
                3: begin
                    // out of range values saturate
                    write_reg(CFG_FIRST_BLANK, 4'd15);
                    write_reg(CFG_SECOND_BLANK, 4'd10);
                end
                4: begin
                    write_reg(CFG_FIRST_BLANK, 4'd5);
                    write_reg(CFG_SECOND_BLANK, 4'd5);
                end
                default: begin
                    write_reg(CFG_FIRST_BLANK, 4'($urandom_range(0, 15)));
                    write_reg(CFG_SECOND_BLANK, 4'($urandom_range(0, 15)));
                    write_reg(2'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                              4'($urandom_range(0, 15)));
                end
            endcase
            while (items_sent < (phase + 1) * RANDOM_ITEMS / NUM_PHASES)
                random_sequence();
        end

        drain();
        @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
